@@ hw/rtl/hsr_pkg.sv @@
// Shared types and constants for the Heron square root block.
package hsr_pkg;

  localparam int STATUS_W   = 2;
  localparam int STEP_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_TOL_MET = 2'd0,
    ST_SETTLED = 2'd1,
    ST_LIMIT   = 2'd2
  } status_e;

  // one operation of the shared add/subtract unit per cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_MUL,
    OP_ERR,
    OP_ERR_REV,
    OP_TOL,
    OP_DIV,
    OP_SUM
  } op_e;

  typedef struct packed {
    logic borrow;   // subtract went negative
    logic settled;  // new estimate equals the old one
  } flags_t;

endpackage

@@ hw/rtl/hsr_in_if.sv @@
// Input channel: one radicand per beat.
interface hsr_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

@@ hw/rtl/hsr_out_if.sv @@
// Output channel: root, status and step count per beat.
interface hsr_out_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [VALUE_BITS-1:0]        root;
  logic [hsr_pkg::STATUS_W-1:0] status;
  logic [hsr_pkg::STEP_W-1:0]   steps_taken;

  modport source (output valid, output root, output status, output steps_taken, input ready);
  modport sink   (input valid, input root, input status, input steps_taken, output ready);
endinterface

@@ hw/rtl/hsr_datapath.sv @@
// Datapath: estimate, radicand, a shared add/subtract unit: square, error, tol, divide, sum.
module hsr_datapath #(
  parameter int VALUE_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                    clk_i,
  input  hsr_pkg::op_e                            op_i,
  input  logic [VALUE_BITS-1:0]                   radicand_i,
  input  logic [((2*FRAC_BITS >= 32) ? 2*FRAC_BITS : 32)-1:0] limit_i,
  output hsr_pkg::flags_t                         flags_o,
  output logic [VALUE_BITS-1:0]                   estimate_o
);

  localparam int V  = VALUE_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NW = V + F;
  localparam int LW = (2*F >= 32) ? 2*F : 32;
  localparam int M1 = (2*V > NW) ? 2*V : NW;
  localparam int AW = ((M1 > LW) ? M1 : LW) + 1;
  localparam logic [V-1:0] ONE = V'(64'(1) << F);

  logic [V-1:0]  e_q, e_d;
  logic [V-1:0]  rad_q, rad_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [NW-1:0] sh_q, sh_d;
  logic [V-1:0]  quo_q, quo_d;
  logic          ovf_q, ovf_d;

  logic [AW-1:0] add_a, add_b;
  logic          add_sub;
  logic [AW:0]   add_r;
  logic [AW-1:0] target;
  logic [AW-1:0] rem_ext;
  logic [V-1:0]  quo_sat;
  logic [V-1:0]  next_est;
  logic          keep;

  assign target  = AW'({rad_q, {F{1'b0}}});
  assign rem_ext = AW'({acc_q[V-1:0], sh_q[NW-1]});
  assign quo_sat = ovf_q ? {V{1'b1}} : quo_q;

  // operand selection for the shared unit
  always_comb begin
    add_a   = acc_q;
    add_b   = '0;
    add_sub = 1'b0;
    case (op_i)
      hsr_pkg::OP_MUL: begin
        add_a = {acc_q[AW-2:0], 1'b0};
        add_b = sh_q[NW-1] ? AW'(e_q) : '0;
      end
      hsr_pkg::OP_ERR: begin
        add_b   = target;
        add_sub = 1'b1;
      end
      hsr_pkg::OP_ERR_REV: begin
        add_a   = target;
        add_b   = acc_q;
        add_sub = 1'b1;
      end
      hsr_pkg::OP_TOL: begin
        add_b   = AW'(limit_i);
        add_sub = 1'b1;
      end
      hsr_pkg::OP_DIV: begin
        add_a   = rem_ext;
        add_b   = AW'(e_q);
        add_sub = 1'b1;
      end
      hsr_pkg::OP_SUM: begin
        add_a = AW'(e_q);
        add_b = AW'(quo_sat);
      end
      default: begin
        add_a = acc_q;
      end
    endcase
  end

  assign add_r    = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (AW+1)'(add_sub);
  assign keep     = add_r[AW];
  assign next_est = add_r[V:1];

  assign flags_o.borrow  = ~add_r[AW];
  assign flags_o.settled = (next_est == e_q);
  assign estimate_o      = e_q;

  always_comb begin
    e_d   = e_q;
    rad_d = rad_q;
    acc_d = acc_q;
    sh_d  = sh_q;
    quo_d = quo_q;
    ovf_d = ovf_q;
    case (op_i)
      hsr_pkg::OP_LOAD: begin
        rad_d = radicand_i;
        e_d   = ONE;
        acc_d = '0;
        sh_d  = {ONE, {F{1'b0}}};
      end
      hsr_pkg::OP_MUL: begin
        acc_d = add_r[AW-1:0];
        sh_d  = sh_q << 1;
      end
      hsr_pkg::OP_ERR: begin
        // keep square minus target when not negative; else the reverse subtract follows
        if (keep) begin
          acc_d = add_r[AW-1:0];
        end
      end
      hsr_pkg::OP_ERR_REV: begin
        acc_d = add_r[AW-1:0];
      end
      hsr_pkg::OP_TOL: begin
        acc_d = '0;
        sh_d  = {rad_q, {F{1'b0}}};
        quo_d = '0;
        ovf_d = 1'b0;
      end
      hsr_pkg::OP_DIV: begin
        acc_d = keep ? add_r[AW-1:0] : rem_ext;
        quo_d = {quo_q[V-2:0], keep};
        ovf_d = ovf_q | quo_q[V-1];
        sh_d  = sh_q << 1;
      end
      hsr_pkg::OP_SUM: begin
        e_d   = next_est;
        acc_d = '0;
        sh_d  = {next_est, {F{1'b0}}};
      end
      default: begin
        e_d = e_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    rad_q <= rad_d;
    acc_q <= acc_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

endmodule

@@ hw/rtl/heron_square_root.sv @@
// Top level: sequencer, configuration registers and result register of the Heron square root.
//
//   channel   dir  handshake      payload
//   in_i      in   valid/ready    radicand
//   out_o     out  valid/ready    root, status, steps_taken
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// One radicand at a time through a single shared add/subtract unit.
// Each check does shift-add squaring of the estimate and an error compare against
// the tolerance; each improvement step adds restoring division of the radicand
// by the estimate and averaging. A zero radicand goes straight to the result beat.
// Reset (rst_ni, async, active low) restores tolerance 4 and step limit 40.
// in_i is ready only while idle; a result beat holds until out_o is taken.
module heron_square_root #(
  parameter int VALUE_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  hsr_in_if.sink                             in_i,
  hsr_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [hsr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hsr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int V      = VALUE_BITS;
  localparam int F      = FRAC_BITS;
  localparam int NW     = V + F;
  localparam int CW     = $clog2(NW);
  localparam int LW     = (2*F >= 32) ? 2*F : 32;
  localparam int SH_UP  = (2*F >= 32) ? 2*F - 32 : 0;
  localparam int SH_DN  = (2*F >= 32) ? 0 : 32 - 2*F;
  localparam logic [LW-1:0] LIMIT_RST = (2*F >= 32) ? LW'(64'(4) << SH_UP)
                                                    : LW'((64'(4) + (64'(1) << SH_DN) - 64'(1)) >> SH_DN);
  localparam logic [hsr_pkg::STEP_W-1:0] ITER_RST = hsr_pkg::STEP_W'(40);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ERR,
    S_ERR_REV,
    S_TOL,
    S_DIV,
    S_SUM,
    S_DONE
  } state_e;

  state_e                        state_q, state_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [hsr_pkg::STEP_W-1:0]    steps_q, steps_d;
  logic [hsr_pkg::STEP_W-1:0]    iter_q;
  logic [LW-1:0]                 limit_q;
  logic [LW-1:0]                 limit_wr;
  logic [V-1:0]                  root_q, root_d;
  hsr_pkg::status_e              status_q, status_d;
  hsr_pkg::op_e                  op;
  hsr_pkg::flags_t               flags;
  logic [V-1:0]                  estimate;
  logic                          in_accept;

  assign in_accept = in_i.valid && in_i.ready;

  // tolerance in 2^-32 units rescaled to 2*FRAC_BITS fraction bits, rounded up
  always_comb begin
    if (2*F >= 32) begin
      limit_wr = LW'(64'(cfg_wdata_i) << SH_UP);
    end else begin
      limit_wr = LW'((64'(cfg_wdata_i) + (64'(1) << SH_DN) - 64'(1)) >> SH_DN);
    end
  end

  hsr_datapath #(
    .VALUE_BITS(VALUE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .op_i      (op),
    .radicand_i(in_i.radicand),
    .limit_i   (limit_q),
    .flags_o   (flags),
    .estimate_o(estimate)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    steps_d  = steps_q;
    root_d   = root_q;
    status_d = status_q;
    op       = hsr_pkg::OP_HOLD;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op      = hsr_pkg::OP_LOAD;
          steps_d = '0;
          cnt_d   = CW'(V - 1);
          if (in_i.radicand == '0) begin
            root_d   = '0;
            status_d = hsr_pkg::ST_TOL_MET;
            state_d  = S_DONE;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        op    = hsr_pkg::OP_MUL;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        op      = hsr_pkg::OP_ERR;
        state_d = flags.borrow ? S_ERR_REV : S_TOL;
      end
      S_ERR_REV: begin
        op      = hsr_pkg::OP_ERR_REV;
        state_d = S_TOL;
      end
      S_TOL: begin
        op     = hsr_pkg::OP_TOL;
        root_d = estimate;
        if (flags.borrow) begin
          status_d = hsr_pkg::ST_TOL_MET;
          state_d  = S_DONE;
        end else if (steps_q >= iter_q) begin
          status_d = hsr_pkg::ST_LIMIT;
          state_d  = S_DONE;
        end else begin
          cnt_d   = CW'(NW - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        op    = hsr_pkg::OP_DIV;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        op      = hsr_pkg::OP_SUM;
        steps_d = steps_q + hsr_pkg::STEP_W'(1);
        cnt_d   = CW'(V - 1);
        if (flags.settled) begin
          root_d   = estimate;
          status_d = hsr_pkg::ST_SETTLED;
          state_d  = S_DONE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_DONE: begin
        // hold the result beat until taken
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      steps_q  <= '0;
      root_q   <= '0;
      status_q <= hsr_pkg::ST_TOL_MET;
      iter_q   <= ITER_RST;
      limit_q  <= LIMIT_RST;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      steps_q  <= steps_d;
      root_q   <= root_d;
      status_q <= status_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hsr_pkg::CFG_TOLERANCE:  limit_q <= limit_wr;
          hsr_pkg::CFG_ITER_LIMIT: iter_q  <= cfg_wdata_i[hsr_pkg::STEP_W-1:0];
          default: begin
            iter_q <= iter_q;
          end
        endcase
      end
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_DONE);
  assign out_o.root        = root_q;
  assign out_o.status      = status_q;
  assign out_o.steps_taken = steps_q;

`ifndef SYNTHESIS
  a_zero_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_i.radicand == '0) |=> (out_o.valid && out_o.root == '0
                                            && out_o.steps_taken == '0))
    else $error("zero radicand did not finish at once");

  a_limit_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == hsr_pkg::ST_LIMIT) |-> (out_o.steps_taken == iter_q))
    else $error("limit status with step count off the cap");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_DONE) |-> (steps_q <= iter_q))
    else $error("step count passed the cap");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("accepting input while a result beat is pending");
`endif

endmodule
